@@ hdl/unit_stream_parser_unit_defines.svh @@
// Assertion helpers for the parser RTL.
`ifndef UNIT_STREAM_PARSER_UNIT_DEFINES_SVH
`define UNIT_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("usp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("usp assertion failed");

`endif

@@ hdl/usp_pkg.sv @@
package usp_pkg;

    localparam logic [1:0] KIND_PSET    = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] REG_PSET_CODE  = 2'd0;
    localparam logic [1:0] REG_INTRA_CODE = 2'd1;
    localparam logic [1:0] REG_PRED_CODE  = 2'd2;

    localparam logic [1:0] CODE_PSET_RST  = 2'd0;
    localparam logic [1:0] CODE_INTRA_RST = 2'd1;
    localparam logic [1:0] CODE_PRED_RST  = 2'd2;

    localparam logic [1:0] PFX_TWO_BYTE = 2'b10;
    localparam logic [5:0] PFX_MASK     = 6'h3f;

    localparam int TDATA_W = 120;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_HEIGHT  = 7'b0000010,
        PH_WIDTH   = 7'b0000100,
        PH_FLAGS   = 7'b0001000,
        PH_QP      = 7'b0010000,
        PH_LENGTH  = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0] pset_code;
        logic [1:0] intra_code;
        logic [1:0] pred_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  unit_type;
        logic [3:0]  set_id;
        logic [29:0] height;
        logic [29:0] width;
        logic        ec_part;
        logic        adaptive_intra;
        logic [7:0]  qp;
        logic [29:0] payload_length;
        logic [7:0]  payload_byte;
        logic        unit_end;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hdl/usp_front.sv @@
module usp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  usp_pkg::cfg_t  cfg,
    input  usp_pkg::q_stat_t q_stat,
    output logic           push,
    output usp_pkg::rec_t  rec
);
    import usp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  type_reg, type_next;
    logic [3:0]  id_reg, id_next;
    logic [29:0] acc_reg, acc_next;
    logic [1:0]  left_reg, left_next;
    logic [29:0] height_reg, height_next;
    logic [29:0] width_reg, width_next;
    logic [7:0]  qp_reg, qp_next;
    logic [29:0] pleft_reg, pleft_next;

    logic        accept;
    logic [29:0] feed_acc;
    logic [1:0]  feed_left;
    logic        feed_done;
    logic [3:0]  hdr_type;
    logic [29:0] pleft_dec;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign hdr_type = s_tdata[7:4];
    assign pleft_dec = pleft_reg - 30'd1;

    // adaptive integer: 1, 2 or 4 byte prefix code
    always_comb begin
        if (left_reg == 2'd0) begin
            if (!s_tdata[7]) begin
                feed_acc  = {22'd0, s_tdata};
                feed_left = 2'd0;
                feed_done = 1'b1;
            end else begin
                feed_acc  = {24'd0, s_tdata[5:0] & PFX_MASK};
                feed_left = (s_tdata[7:6] == PFX_TWO_BYTE) ? 2'd1 : 2'd3;
                feed_done = 1'b0;
            end
        end else begin
            feed_acc  = {acc_reg[21:0], s_tdata};
            feed_left = left_reg - 2'd1;
            feed_done = (left_reg == 2'd1);
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        id_next     = id_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        height_next = height_reg;
        width_next  = width_reg;
        qp_next     = qp_reg;
        pleft_next  = pleft_reg;
        push        = 1'b0;
        rec         = '0;
        rec.unit_type = type_reg;
        rec.set_id    = id_reg;
        if (accept) begin
            case (phase_reg)
                PH_HEIGHT: begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done) begin
                        height_next = feed_acc;
                        phase_next  = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done) begin
                        width_next = feed_acc;
                        phase_next = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    push               = 1'b1;
                    rec.kind           = KIND_PSET;
                    rec.height         = height_reg;
                    rec.width          = width_reg;
                    rec.ec_part        = s_tdata[2];
                    rec.adaptive_intra = s_tdata[0];
                    rec.unit_end       = 1'b1;
                    phase_next         = PH_HEADER;
                end
                PH_QP: begin
                    qp_next    = s_tdata;
                    left_next  = 2'd0;
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH: begin
                    acc_next  = feed_acc;
                    left_next = feed_left;
                    if (feed_done) begin
                        pleft_next         = feed_acc;
                        push               = 1'b1;
                        rec.kind           = KIND_FRAME;
                        rec.qp             = qp_reg;
                        rec.payload_length = feed_acc;
                        rec.unit_end       = (feed_acc == 30'd0);
                        phase_next = (feed_acc == 30'd0) ? PH_HEADER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    pleft_next       = pleft_dec;
                    push             = 1'b1;
                    rec.kind         = KIND_PAYLOAD;
                    rec.payload_byte = s_tdata;
                    rec.unit_end     = (pleft_dec == 30'd0);
                    if (pleft_dec == 30'd0) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    type_next     = hdr_type;
                    id_next       = s_tdata[3:0];
                    left_next     = 2'd0;
                    rec.unit_type = hdr_type;
                    rec.set_id    = s_tdata[3:0];
                    if (hdr_type == {2'b00, cfg.pset_code}) begin
                        phase_next = PH_HEIGHT;
                    end else if (hdr_type == {2'b00, cfg.intra_code} ||
                                 hdr_type == {2'b00, cfg.pred_code}) begin
                        phase_next = PH_QP;
                    end else begin
                        push         = 1'b1;
                        rec.kind     = KIND_ERROR;
                        rec.unit_end = 1'b1;
                        phase_next   = PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            type_reg   <= '0;
            id_reg     <= '0;
            acc_reg    <= '0;
            left_reg   <= '0;
            height_reg <= '0;
            width_reg  <= '0;
            qp_reg     <= '0;
            pleft_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            id_reg     <= id_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            qp_reg     <= qp_next;
            pleft_reg  <= pleft_next;
        end
    end

endmodule

@@ hdl/usp_queue.sv @@
module usp_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  usp_pkg::rec_t    push_rec,
    input  logic             pop,
    output usp_pkg::rec_t    head_rec,
    output usp_pkg::q_stat_t q_stat
);
    import usp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rec_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_rec     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/usp_back.sv @@
module usp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  usp_pkg::q_stat_t            q_stat,
    input  usp_pkg::rec_t               head_rec,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [usp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);
    import usp_pkg::*;

    logic valid_reg, valid_next;
    rec_t out_reg;
    logic load;

    assign load       = !valid_reg || m_tready;
    assign pop        = load && !q_stat.empty;
    assign valid_next = load ? !q_stat.empty : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head_rec;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.unit_end;
    assign m_tdata  = {4'd0, out_reg.payload_byte, out_reg.payload_length, out_reg.qp,
                       out_reg.adaptive_intra, out_reg.ec_part, out_reg.width,
                       out_reg.height, out_reg.set_id, out_reg.unit_type};

endmodule

@@ hdl/unit_stream_parser_unit.sv @@
// Throughput: one stream byte per cycle, sustained while m_tready stays high.
// A result reaches m_ after the byte that completes it is taken: parser step into the
// result queue, then the output register.
// The input stalls only when the QUEUE_DEPTH-entry result queue is full.
// Reset (aresetn low, synchronous): parser expects a header, all held values zero,
// queue empty, type codes back to 0 / 1 / 2.
`include "unit_stream_parser_unit_defines.svh"

module unit_stream_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] byte_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [3:0] unit_type, [7:4] set_id, [37:8] height, [67:38] width, [68] ec_part,
    // [69] adaptive_intra, [77:70] qp, [107:78] payload_length,
    // [115:108] payload_byte, [119:116] zero
    output logic [usp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,  // [1:0] kind
    output logic                        m_tlast,  // unit_end
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [1:0]                  cfg_wdata
);
    import usp_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    rec_t    push_rec, head_rec;
    logic    push, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PSET_CODE:  cfg_next.pset_code  = cfg_wdata;
                REG_INTRA_CODE: cfg_next.intra_code = cfg_wdata;
                REG_PRED_CODE:  cfg_next.pred_code  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pset_code  <= CODE_PSET_RST;
            cfg_reg.intra_code <= CODE_INTRA_RST;
            cfg_reg.pred_code  <= CODE_PRED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    usp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (push),
        .rec      (push_rec)
    );

    usp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    usp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_rec (head_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `USP_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !q_stat.full)
    `USP_ASSERT_IMP(a_error_closes, aclk, aresetn, m_tvalid && m_tuser == KIND_ERROR, m_tlast)
    `USP_ASSERT_IMP(a_pset_closes, aclk, aresetn, m_tvalid && m_tuser == KIND_PSET, m_tlast)
    `USP_ASSERT_NXT(a_push_shows, aclk, aresetn, push, !q_stat.empty)

endmodule
